>>> hdl/rbfe_pkg.sv
`timescale 1ns / 1ps
// Package for the record bit-field extractor: transaction types, register
// indexes, type and status codes, and the shared window-length helpers.
package rbfe_pkg;

    // Record length limit; bytes past it are dropped and the counter saturates
    localparam int MAX_RECORD_BYTES = 256;
    // Longest field window: 7 bits of offset plus 64 bits of field
    localparam int WINDOW_BYTES     = 9;
    localparam int WIN_IDX_W        = $clog2(WINDOW_BYTES);
    localparam int POS_W            = $clog2(MAX_RECORD_BYTES + 1);
    // Width for position compares against byte offset plus window length
    localparam int CMP_W            = (POS_W > 9) ? POS_W : 9;

    // Configuration register indexes
    localparam logic [1:0] REG_BYTE_OFFSET = 2'd0;
    localparam logic [1:0] REG_BIT_OFFSET  = 2'd1;
    localparam logic [1:0] REG_BIT_COUNT   = 2'd2;
    localparam logic [1:0] REG_VALUE_TYPE  = 2'd3;

    // Value type codes; anything above TYPE_TEXT is unsupported
    localparam logic [2:0] TYPE_UINT_LE = 3'd0;
    localparam logic [2:0] TYPE_UINT_BE = 3'd1;
    localparam logic [2:0] TYPE_INT_LE  = 3'd2;
    localparam logic [2:0] TYPE_INT_BE  = 3'd3;
    localparam logic [2:0] TYPE_TEXT    = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_UNSUPPORTED = 2'd1,
        STATUS_BEYOND_END  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       end_of_record;
    } in_item_t;

    typedef struct packed {
        logic [63:0] field_value;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [7:0] field_byte_offset;
        logic [2:0] field_bit_offset;
        logic [6:0] field_bit_count;
        logic [2:0] value_type;
    } cfg_t;

    typedef logic [WINDOW_BYTES-1:0][7:0] window_t;

    // Finished record handed from capture to formatting
    typedef struct packed {
        window_t          bytes;
        logic [POS_W-1:0] length;
    } snap_t;

    // Bit count with zero read as one and anything above 64 as 64
    function automatic logic [6:0] eff_count(input logic [6:0] c);
        logic [6:0] r;
        if (c == 7'd0)
            r = 7'd1;
        else if (c > 7'd64)
            r = 7'd64;
        else
            r = c;
        return r;
    endfunction

    // Bytes covered by the field: ceil((bit_offset + bit_count) / 8)
    function automatic logic [3:0] window_len(input logic [2:0] off, input logic [6:0] c);
        logic [6:0] sum;
        sum = 7'(off) + eff_count(c) + 7'd7;
        return 4'(sum >> 3);
    endfunction

endpackage

>>> hdl/record_bit_field_extractor.sv
`timescale 1ns / 1ps
// Record bit-field extractor top level: configuration registers and the
// capture and format stages. Depends on rbfe_pkg, rbfe_capture, rbfe_format.
//
// Usage: records stream in one byte per input transaction (in_valid/in_stall),
// with end_of_record set on the last byte. For each record one result
// transaction leaves on out_valid/out_stall: the configured field, zero- or
// sign-extended to 64 bits, and a status (ok, unsupported type, or field past
// the end of the record). Bytes that are not the last give no result.
// Throughput is one byte per cycle while in_stall is low. A result passes from its
// last accepted byte into the snapshot register, then through the formatting
// logic into the output register.
// When the receiver stalls, the output register holds its transaction and the
// snapshot register holds the next finished record; once both are occupied,
// in_stall rises and holds every input byte, last or not, until the output
// transaction is taken.
// Reset clears the byte counter, window and both valid flags, and loads the
// register defaults (byte offset 0, bit offset 0, bit count 8, unsigned LE).
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant for idle periods between records.
module record_bit_field_extractor import rbfe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  accept;
    logic  take;
    logic  snap_valid;
    snap_t snap;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_byte_offset <= 8'd0;
            cfg_reg.field_bit_offset  <= 3'd0;
            cfg_reg.field_bit_count   <= 7'd8;
            cfg_reg.value_type        <= TYPE_UINT_LE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BYTE_OFFSET: cfg_reg.field_byte_offset <= cfg_data;
                REG_BIT_OFFSET:  cfg_reg.field_bit_offset  <= cfg_data[2:0];
                REG_BIT_COUNT:   cfg_reg.field_bit_count   <= cfg_data[6:0];
                REG_VALUE_TYPE:  cfg_reg.value_type        <= cfg_data[2:0];
            endcase
        end
    end

    // Input flow control: stall only while the snapshot cannot move on
    assign in_stall = snap_valid && !take;
    assign accept   = in_valid && !in_stall;

    rbfe_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (in_data),
        .cfg        (cfg_reg),
        .take       (take),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    rbfe_format u_format (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .cfg        (cfg_reg),
        .out_stall  (out_stall),
        .take       (take),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

endmodule

>>> hdl/rbfe_capture.sv
`timescale 1ns / 1ps
// Capture stage: byte position counter, field window bytes, and the record
// snapshot register taken at the last byte. Depends on rbfe_pkg.
module rbfe_capture import rbfe_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    input  cfg_t     cfg,
    input  logic     take,
    output logic     snap_valid,
    output snap_t    snap
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    window_t          window_reg;
    window_t          window_next;
    logic             snap_valid_reg;
    logic             snap_valid_next;
    snap_t            snap_reg;
    logic [3:0]       win_len;
    logic [CMP_W-1:0] rel_pos;
    logic             hit;

    assign win_len = window_len(cfg.field_bit_offset, cfg.field_bit_count);

    // Window hit test and byte write for the incoming byte
    always_comb
    begin
        rel_pos = CMP_W'(pos_reg) - CMP_W'(cfg.field_byte_offset);
        hit = (pos_reg < POS_W'(MAX_RECORD_BYTES))
              && (CMP_W'(pos_reg) >= CMP_W'(cfg.field_byte_offset))
              && (rel_pos < CMP_W'(win_len));
        window_next = window_reg;
        for (int i = 0; i < WINDOW_BYTES; i++)
        begin
            if (hit && (rel_pos[WIN_IDX_W-1:0] == WIN_IDX_W'(i)))
                window_next[i] = item.record_byte;
        end
        if (pos_reg < POS_W'(MAX_RECORD_BYTES))
            pos_next = pos_reg + POS_W'(1);
        else
            pos_next = pos_reg;
    end

    // Snapshot valid: set by a last byte, cleared when formatting takes it
    always_comb
    begin
        if (accept && item.end_of_record)
            snap_valid_next = 1'b1;
        else if (take)
            snap_valid_next = 1'b0;
        else
            snap_valid_next = snap_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (accept)
                pos_reg <= item.end_of_record ? '0 : pos_next;
        end
    end

    // Window bytes; cleared at the end of each record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (accept)
            window_reg <= item.end_of_record ? '0 : window_next;
    end

    // Snapshot payload
    always_ff @(posedge clk)
    begin
        if (accept && item.end_of_record)
        begin
            snap_reg.bytes  <= window_next;
            snap_reg.length <= pos_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

>>> hdl/rbfe_format.sv
`timescale 1ns / 1ps
// Format stage: byte ordering, bit shift, mask, sign extension and status,
// into the output register. Depends on rbfe_pkg.
module rbfe_format import rbfe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      snap_valid,
    input  snap_t     snap,
    input  cfg_t      cfg,
    input  logic      out_stall,
    output logic      take,
    output logic      out_valid,
    output out_item_t out_data
);

    logic             out_valid_reg;
    out_item_t        out_data_reg;
    out_item_t        out_data_next;
    logic             load;
    logic [3:0]       win_len;
    logic [6:0]       cnt;
    logic             big;
    logic             sgn;
    logic [71:0]      word;
    logic [71:0]      shifted;
    logic [63:0]      mask;
    logic [63:0]      value;
    logic [3:0]       src;
    logic [CMP_W-1:0] field_end;

    assign load = !out_valid_reg || !out_stall;
    assign take = snap_valid && load;

    assign win_len = window_len(cfg.field_bit_offset, cfg.field_bit_count);
    assign cnt     = eff_count(cfg.field_bit_count);
    assign big     = (cfg.value_type == TYPE_UINT_BE) || (cfg.value_type == TYPE_INT_BE);
    assign sgn     = (cfg.value_type == TYPE_INT_LE) || (cfg.value_type == TYPE_INT_BE);

    // Assemble the window word, first byte lowest or highest
    always_comb
    begin
        word = '0;
        src  = '0;
        for (int j = 0; j < WINDOW_BYTES; j++)
        begin
            if (4'(j) < win_len)
            begin
                src = big ? (win_len - 4'd1 - 4'(j)) : 4'(j);
                word[8*j +: 8] = snap.bytes[src[WIN_IDX_W-1:0]];
            end
        end
    end

    // Shift, mask, sign extend
    always_comb
    begin
        shifted = word >> cfg.field_bit_offset;
        mask    = ~64'd0 >> (7'd64 - cnt);
        value   = shifted[63:0] & mask;
        if (sgn && (cnt > 7'd1) && value[6'(cnt - 7'd1)])
            value = value | ~mask;
    end

    // Status and result
    always_comb
    begin
        field_end = CMP_W'(cfg.field_byte_offset) + CMP_W'(win_len);
        if (cfg.value_type > TYPE_TEXT)
        begin
            out_data_next.status      = STATUS_UNSUPPORTED;
            out_data_next.field_value = '0;
        end
        else if (field_end > CMP_W'(snap.length))
        begin
            out_data_next.status      = STATUS_BEYOND_END;
            out_data_next.field_value = '0;
        end
        else
        begin
            out_data_next.status      = STATUS_OK;
            out_data_next.field_value = value;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for record_bit_field_extractor: random and directed records against
// a field predictor, with random gaps on both channels. Depends on rbfe_pkg.
module tb_top;
    import rbfe_pkg::*;

    localparam int          ITEM_TARGET         = 1450;
    localparam int          SETTLE_CYCLES       = 4;
    localparam int          MAX_FIELD_BITS      = 64;
    localparam logic [2:0]  TYPE_RESERVED_FIRST = 3'd5;
    localparam logic [2:0]  TYPE_RESERVED_LAST  = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_BYTE_OFFSET;
    logic [7:0] cfg_data = '0;

    // Stimulus and result bookkeeping
    in_item_t    pending_bytes[$];
    out_item_t   expected_fields[$];
    int unsigned items_queued = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_count = 0;

    // Predictor copy of the field registers and the capture state
    logic [7:0]  mdl_byte_off = 8'd0;
    logic [2:0]  mdl_bit_off = 3'd0;
    logic [6:0]  mdl_bit_cnt = 7'd8;
    logic [2:0]  mdl_type = TYPE_UINT_LE;
    int unsigned mdl_pos = 0;
    logic [7:0]  mdl_win [WINDOW_BYTES] = '{default: '0};

    record_bit_field_extractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic flag_error(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Bit count with zero read as one and large counts clamped to 64
    function automatic int unsigned field_width();
        if (mdl_bit_cnt == 7'd0)
            return 1;
        if (mdl_bit_cnt > MAX_FIELD_BITS)
            return MAX_FIELD_BITS;
        return 32'(mdl_bit_cnt);
    endfunction

    function automatic int unsigned window_bytes();
        return (32'(mdl_bit_off) + field_width() + 7) / 8;
    endfunction

    // Assemble the captured window, shift, mask and sign-extend
    function automatic logic [63:0] extract_field();
        int unsigned n;
        int unsigned cnt;
        int unsigned sh;
        logic [127:0] acc;
        logic [63:0]  v;
        logic [63:0]  mask;
        logic         big;
        logic         sgn;
        n   = window_bytes();
        cnt = field_width();
        big = (mdl_type == TYPE_UINT_BE) || (mdl_type == TYPE_INT_BE);
        sgn = (mdl_type == TYPE_INT_LE) || (mdl_type == TYPE_INT_BE);
        acc = '0;
        for (int i = 0; i < n; i++)
        begin
            sh = big ? 8 * (n - 1 - i) : 8 * i;
            acc |= 128'(mdl_win[i]) << sh;
        end
        v    = 64'(acc >> mdl_bit_off);
        mask = (cnt < MAX_FIELD_BITS) ? ((64'd1 << cnt) - 64'd1) : '1;
        v &= mask;
        // one-bit signed fields stay 0/1
        if (sgn && cnt > 1 && cnt < MAX_FIELD_BITS && v[cnt-1])
            v |= ~mask;
        return v;
    endfunction

    // Advance the predictor by one accepted byte; queue a result at record end
    task automatic take_record_byte(in_item_t it);
        int unsigned n;
        out_item_t   res;
        n = window_bytes();
        if (mdl_pos < MAX_RECORD_BYTES)
        begin
            if (mdl_pos >= mdl_byte_off && mdl_pos - mdl_byte_off < n)
                mdl_win[mdl_pos - mdl_byte_off] = it.record_byte;
            mdl_pos++;
        end
        if (it.end_of_record)
        begin
            res.field_value = '0;
            if (mdl_type > TYPE_TEXT)
                res.status = STATUS_UNSUPPORTED;
            else if (mdl_byte_off + n > mdl_pos)
                res.status = STATUS_BEYOND_END;
            else
            begin
                res.status      = STATUS_OK;
                res.field_value = extract_field();
            end
            expected_fields.push_back(res);
            mdl_pos = 0;
            foreach (mdl_win[i])
                mdl_win[i] = '0;
        end
    endtask

    // Driver: one byte transaction per slot, random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                take_record_byte(in_data);
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_data  <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_fields.size() == 0)
                    flag_error($sformatf("result with none pending: value %h status %0d",
                                         out_data.field_value, out_data.status));
                else
                begin
                    want = expected_fields.pop_front();
                    if (out_data.field_value !== want.field_value)
                        flag_error($sformatf("field_value %h, predicted %h",
                                             out_data.field_value, want.field_value));
                    if (out_data.status !== want.status)
                        flag_error($sformatf("status %0d, predicted %0d",
                                             out_data.status, want.status));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic add_byte(logic [7:0] b, logic last);
        in_item_t it;
        it.record_byte   = b;
        it.end_of_record = last;
        pending_bytes.push_back(it);
        items_queued++;
    endtask

    task automatic add_record(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            add_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    // One register write; the predictor copy follows at once (block is idle)
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_BYTE_OFFSET: mdl_byte_off = val;
            REG_BIT_OFFSET:  mdl_bit_off  = val[2:0];
            REG_BIT_COUNT:   mdl_bit_cnt  = val[6:0];
            REG_VALUE_TYPE:  mdl_type     = val[2:0];
            default: ;
        endcase
    endtask

    task automatic program_field(logic [7:0] boff, logic [2:0] bitoff, logic [6:0] cnt,
                                 logic [2:0] vt);
        write_reg(REG_BYTE_OFFSET, boff);
        write_reg(REG_BIT_OFFSET, 8'(bitoff));
        write_reg(REG_BIT_COUNT, 8'(cnt));
        write_reg(REG_VALUE_TYPE, 8'(vt));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every byte is taken and every result is back, then settle
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || expected_fields.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [6:0] random_bit_count();
        case ($urandom_range(9))
            0:       return 7'd0;
            1:       return 7'($urandom_range(127, MAX_FIELD_BITS + 1));
            2:       return 7'(MAX_FIELD_BITS);
            3:       return 7'd1;
            default: return 7'($urandom_range(MAX_FIELD_BITS, 1));
        endcase
    endfunction

    function automatic logic [2:0] random_value_type();
        if ($urandom_range(7) == 0)
            return 3'($urandom_range(TYPE_RESERVED_LAST, TYPE_RESERVED_FIRST));
        return 3'($urandom_range(TYPE_TEXT));
    endfunction

    // Idle mix follows how far the run has got
    task automatic pick_idle_mix();
        if (items_queued < ITEM_TARGET / 3)
        begin
            send_gap_pct   = 23;
            recv_stall_pct = 48;
        end
        else if (items_queued < 2 * ITEM_TARGET / 3)
        begin
            send_gap_pct   = 48;
            recv_stall_pct = 23;
        end
        else
        begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end
    endtask

    // Main sequence
    initial
    begin
        int unsigned phase;
        int unsigned n;
        int unsigned short_len;
        int unsigned rlen;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        pick_idle_mix();

        // reset defaults, one-byte records at the byte extremes
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b1);
        wait_idle();
        // unsupported types
        program_field(8'd0, 3'd0, 7'd8, TYPE_RESERVED_FIRST);
        add_byte(8'h5A, 1'b1);
        wait_idle();
        program_field(8'd0, 3'd0, 7'd8, TYPE_RESERVED_LAST);
        add_byte(8'hA5, 1'b1);
        wait_idle();
        // field past the record end
        program_field(8'd3, 3'd0, 7'd8, TYPE_UINT_LE);
        add_byte(8'h11, 1'b0);
        add_byte(8'h22, 1'b1);
        wait_idle();
        // one-bit signed field reads as 0/1
        program_field(8'd0, 3'd7, 7'd1, TYPE_INT_LE);
        add_byte(8'h80, 1'b1);
        wait_idle();
        // zero bit count is taken as one
        program_field(8'd0, 3'd0, 7'd0, TYPE_INT_BE);
        add_byte(8'h01, 1'b1);
        wait_idle();
        // widest window: bit offset 7, count above 64 clamped, signed BE
        program_field(8'd0, 3'd7, 7'd127, TYPE_INT_BE);
        repeat (8) add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b1);
        wait_idle();
        // text field across two bytes
        program_field(8'd1, 3'd4, 7'd12, TYPE_TEXT);
        add_byte(8'h12, 1'b0);
        add_byte(8'h34, 1'b0);
        add_byte(8'hC7, 1'b1);
        wait_idle();
        // registers changed in the middle of a record
        program_field(8'd0, 3'd0, 7'd8, TYPE_UINT_LE);
        add_byte(8'h9C, 1'b0);
        wait_idle();
        program_field(8'd0, 3'd0, 7'd16, TYPE_INT_LE);
        add_byte(8'hE1, 1'b1);
        wait_idle();

        // random phases, each under its own field setting
        phase = 0;
        while (items_queued < ITEM_TARGET)
        begin
            pick_idle_mix();
            if (phase == 4)
            begin
                // full-length record with the window on its last nine bytes
                program_field(8'd247, 3'd7, 7'(MAX_FIELD_BITS), 3'($urandom_range(3)));
                add_record(MAX_RECORD_BYTES);
            end
            else if (phase == 10)
            begin
                // overlong record, field at the last byte offset
                program_field(8'd255, 3'($urandom_range(7)), random_bit_count(),
                              random_value_type());
                add_record(MAX_RECORD_BYTES + $urandom_range(40, 1));
            end
            else
            begin
                program_field(8'($urandom_range(12)), 3'($urandom_range(7)),
                              random_bit_count(), random_value_type());
                n = window_bytes();
                short_len = mdl_byte_off + n - 1;
                repeat ($urandom_range(6, 3))
                begin
                    if ($urandom_range(7) == 0)
                        rlen = (short_len == 0) ? 1 : $urandom_range(short_len, 1);
                    else
                        rlen = mdl_byte_off + n + $urandom_range(3);
                    add_record(rlen);
                end
                // sometimes leave a record open across the next register change
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(3, 1)) add_byte(8'($urandom_range(255)), 1'b0);
            end
            wait_idle();
            phase++;
        end

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> record_bit_field_extractor.f
hdl/rbfe_pkg.sv
hdl/rbfe_capture.sv
hdl/rbfe_format.sv
hdl/record_bit_field_extractor.sv
verif/tb_top.sv
